FILE: hdl/dpsl_pkg.sv
// Shared types, register codes and Q16.16 helpers for the decimated PI speed loop.
// No dependencies; every other file of the block imports this package.
package dpsl_pkg;

	// Register index codes of the configuration port
	typedef enum logic [2:0] {
		REG_RATED_SPEED    = 3'd0,
		REG_PROP_GAIN      = 3'd1,
		REG_INTEG_GAIN     = 3'd2,
		REG_DAMPING_FACTOR = 3'd3,
		REG_INV_POLE_PAIRS = 3'd4,
		REG_MAX_Q_CURRENT  = 3'd5,
		REG_PERIOD_TICKS   = 3'd6,
		REG_TICK_TIME      = 3'd7
	} cfg_reg_t;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 31;
	localparam int GAIN_W     = 31;
	localparam int PERIOD_W   = 16;
	localparam int Q_W        = 32;

	localparam logic [GAIN_W-1:0]   RST_RATED_SPEED = 31'd65536;
	localparam logic [GAIN_W-1:0]   RST_PROP_GAIN   = 31'd65536;
	localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN  = 31'd65536;
	localparam logic [GAIN_W-1:0]   RST_DAMPING     = 31'd65536;
	localparam logic [GAIN_W-1:0]   RST_INV_PP      = 31'd32768;
	localparam logic [GAIN_W-1:0]   RST_MAX_Q_CUR   = 31'd65536;
	localparam logic [PERIOD_W-1:0] RST_PERIOD      = 16'd1;
	localparam logic [GAIN_W-1:0]   RST_TICK_TIME   = 31'd13;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	// Queue depths (power of two, pointers wrap naturally)
	localparam int JQ_DEPTH = 2;
	localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

	typedef struct packed {
		logic [GAIN_W-1:0]   rated_speed;
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integ_gain;
		logic [GAIN_W-1:0]   damping_factor;
		logic [GAIN_W-1:0]   inverse_pole_pairs;
		logic [GAIN_W-1:0]   max_q_current;
		logic [PERIOD_W-1:0] period_ticks;
		logic [GAIN_W-1:0]   tick_time;
	} cfg_t;

	// One controller update handed from the front to the back
	typedef struct packed {
		logic signed [Q_W-1:0] speed_command;
		logic signed [Q_W-1:0] measured_speed;
		logic                  startup;
		logic [GAIN_W-1:0]     elapsed_time;
	} job_t;

	// Saturate a 33-bit sum or difference to 32 bits
	function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] s);
		logic signed [Q_W-1:0] r;
		if (s[Q_W] != s[Q_W-1]) begin
			r = s[Q_W] ? Q_MIN : Q_MAX;
		end else begin
			r = s[Q_W-1:0];
		end
		return r;
	endfunction

	// Q16.16 multiply: exact product, floor shift by 16, saturate
	function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [2*Q_W-1:0] p;
		logic [2*Q_W-17:0]       q;
		logic signed [Q_W-1:0]   r;
		p = a * b;
		q = p[2*Q_W-1:16];
		if (!q[2*Q_W-17] && (|q[2*Q_W-18:Q_W-1])) begin
			r = Q_MAX;
		end else if (q[2*Q_W-17] && !(&q[2*Q_W-18:Q_W-1])) begin
			r = Q_MIN;
		end else begin
			r = q[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/dpsl_cfg_regs.sv
// Configuration register file of the speed loop.
// Depends on dpsl_pkg (cfg_t, register codes, reset values).
module dpsl_cfg_regs import dpsl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Write the addressed register, truncated to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rated_speed        <= RST_RATED_SPEED;
			cfg_q.prop_gain          <= RST_PROP_GAIN;
			cfg_q.integ_gain         <= RST_INTEG_GAIN;
			cfg_q.damping_factor     <= RST_DAMPING;
			cfg_q.inverse_pole_pairs <= RST_INV_PP;
			cfg_q.max_q_current      <= RST_MAX_Q_CUR;
			cfg_q.period_ticks       <= RST_PERIOD;
			cfg_q.tick_time          <= RST_TICK_TIME;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_addr))
				REG_RATED_SPEED:    cfg_q.rated_speed        <= cfg_wdata;
				REG_PROP_GAIN:      cfg_q.prop_gain          <= cfg_wdata;
				REG_INTEG_GAIN:     cfg_q.integ_gain         <= cfg_wdata;
				REG_DAMPING_FACTOR: cfg_q.damping_factor     <= cfg_wdata;
				REG_INV_POLE_PAIRS: cfg_q.inverse_pole_pairs <= cfg_wdata;
				REG_MAX_Q_CURRENT:  cfg_q.max_q_current      <= cfg_wdata;
				REG_PERIOD_TICKS:   cfg_q.period_ticks       <= cfg_wdata[PERIOD_W-1:0];
				REG_TICK_TIME:      cfg_q.tick_time          <= cfg_wdata;
				default:            cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/dpsl_front.sv
// Front end: takes sample ticks, counts them, accumulates elapsed time and
// queues a job when the control period is reached. Depends on dpsl_pkg.
module dpsl_front import dpsl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [Q_W-1:0] speed_command,
	input  logic signed [Q_W-1:0] measured_speed,
	input  logic                  startup,
	input  logic [PERIOD_W-1:0]   period_ticks,
	input  logic [GAIN_W-1:0]     tick_time,
	input  logic                  jq_full,
	output logic                  job_push,
	output job_t                  job
);

	logic [PERIOD_W-1:0] tick_q;
	logic [GAIN_W-1:0]   elap_q;
	logic [PERIOD_W-1:0] tick_nxt;
	logic [GAIN_W:0]     elap_sum;
	logic [GAIN_W-1:0]   elap_nxt;
	logic                accept;
	logic                fire;

	// Stall ticks while the job queue cannot take an update
	assign full   = jq_full;
	assign accept = push && !jq_full;

	// Advance the count and the saturating time sum; period zero acts as one
	assign tick_nxt = tick_q + PERIOD_W'(1);
	assign elap_sum = {1'b0, elap_q} + {1'b0, tick_time};
	assign elap_nxt = elap_sum[GAIN_W] ? {GAIN_W{1'b1}} : elap_sum[GAIN_W-1:0];
	assign fire     = tick_nxt >= period_ticks;

	assign job_push           = accept && fire;
	assign job.speed_command  = speed_command;
	assign job.measured_speed = measured_speed;
	assign job.startup        = startup;
	assign job.elapsed_time   = elap_nxt;

	// Hold counters, restart them after an update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			elap_q <= '0;
		end else if (accept) begin
			if (fire) begin
				tick_q <= '0;
				elap_q <= '0;
			end else begin
				tick_q <= tick_nxt;
				elap_q <= elap_nxt;
			end
		end
	end

endmodule

FILE: hdl/dpsl_job_queue.sv
// Short queue of pending controller updates between front and back.
// Depends on dpsl_pkg (job_t, JQ_DEPTH).
module dpsl_job_queue import dpsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	output logic valid,
	input  logic rd_en,
	output job_t rd_job
);

	job_t                mem_q [JQ_DEPTH];
	logic [JQ_PTR_W-1:0] wr_ptr_q;
	logic [JQ_PTR_W-1:0] rd_ptr_q;
	logic [JQ_PTR_W:0]   cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign full   = cnt_q == (JQ_PTR_W+1)'(JQ_DEPTH);
	assign valid  = cnt_q != '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && valid;
	assign rd_job = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + JQ_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + JQ_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (JQ_PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (JQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: hdl/dpsl_back.sv
// Back end: runs the PI update on one shared Q16.16 multiplier and holds the
// integral; a two-entry result queue feeds the output. Depends on dpsl_pkg.
module dpsl_back import dpsl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  job_valid,
	input  job_t                  job,
	output logic                  job_take,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [Q_W-1:0] q_current_ref
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WREF,
		ST_DW,
		ST_KI,
		ST_KPD,
		ST_A_IPP,
		ST_KP_ABS,
		ST_A_TIME,
		ST_C_IPP,
		ST_B_IPP,
		ST_CLAMP,
		ST_OUT
	} state_t;

	state_t                state_q;
	job_t                  job_q;
	logic signed [Q_W-1:0] wref_q, dw_q, err_q, d_q, absd_q;
	logic signed [Q_W-1:0] a_q, b_q, c_q, lim_q, integ_q;
	logic signed [Q_W-1:0] mul_a, mul_b, mul_res;
	logic signed [Q_W-1:0] y;
	logic signed [Q_W-1:0] neg_lim;
	logic signed [Q_W-1:0] rated, kp, ki, damp, ipp, iqmax, elap;

	logic signed [Q_W-1:0] oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   oq_wr_q;
	logic [OQ_PTR_W-1:0]   oq_rd_q;
	logic [OQ_PTR_W:0]     oq_cnt_q;
	logic                  oq_full;
	logic                  oq_push;
	logic                  oq_pop;

	assign rated = {1'b0, cfg.rated_speed};
	assign kp    = {1'b0, cfg.prop_gain};
	assign ki    = {1'b0, cfg.integ_gain};
	assign damp  = {1'b0, cfg.damping_factor};
	assign ipp   = {1'b0, cfg.inverse_pole_pairs};
	assign iqmax = {1'b0, cfg.max_q_current};
	assign elap  = {1'b0, job_q.elapsed_time};

	// Select the operands of the shared multiplier for each step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_WREF:   begin mul_a = rated; mul_b = job_q.speed_command; end
			ST_DW:     begin mul_a = damp;  mul_b = wref_q; end
			ST_KI:     begin mul_a = ki;    mul_b = err_q; end
			ST_KPD:    begin mul_a = kp;    mul_b = d_q; end
			ST_A_IPP:  begin mul_a = a_q;   mul_b = ipp; end
			ST_KP_ABS: begin mul_a = kp;    mul_b = absd_q; end
			ST_A_TIME: begin mul_a = a_q;   mul_b = elap; end
			ST_C_IPP:  begin mul_a = c_q;   mul_b = ipp; end
			ST_B_IPP:  begin mul_a = b_q;   mul_b = ipp; end
			default:   begin mul_a = '0;    mul_b = '0; end
		endcase
	end

	assign mul_res = qmul(mul_a, mul_b);
	assign y       = sat33({b_q[Q_W-1], b_q} + {integ_q[Q_W-1], integ_q});
	assign neg_lim = -lim_q;

	assign oq_full  = oq_cnt_q == (OQ_PTR_W+1)'(OQ_DEPTH);
	assign oq_push  = (state_q == ST_OUT) && !oq_full;
	assign job_take = job_valid && ((state_q == ST_IDLE) || oq_push);

	// Sequence one update: products go through the multiplier, sums ride along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integ_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_take) begin
						state_q <= ST_WREF;
					end
				end
				ST_WREF: begin
					wref_q  <= mul_res;
					state_q <= ST_DW;
				end
				ST_DW: begin
					dw_q    <= mul_res;
					err_q   <= sat33({wref_q[Q_W-1], wref_q} -
						{job_q.measured_speed[Q_W-1], job_q.measured_speed});
					state_q <= ST_KI;
				end
				ST_KI: begin
					a_q     <= mul_res;
					d_q     <= sat33({dw_q[Q_W-1], dw_q} -
						{job_q.measured_speed[Q_W-1], job_q.measured_speed});
					state_q <= ST_KPD;
				end
				ST_KPD: begin
					b_q     <= mul_res;
					absd_q  <= d_q[Q_W-1] ? sat33(-{d_q[Q_W-1], d_q}) : d_q;
					state_q <= ST_A_IPP;
				end
				ST_A_IPP: begin
					a_q     <= mul_res;
					state_q <= ST_KP_ABS;
				end
				ST_KP_ABS: begin
					c_q     <= mul_res;
					state_q <= ST_A_TIME;
				end
				ST_A_TIME: begin
					a_q     <= mul_res;
					state_q <= ST_C_IPP;
				end
				ST_C_IPP: begin
					c_q     <= mul_res;
					integ_q <= sat33({integ_q[Q_W-1], integ_q} + {a_q[Q_W-1], a_q});
					state_q <= ST_B_IPP;
				end
				ST_B_IPP: begin
					b_q     <= mul_res;
					lim_q   <= sat33({c_q[Q_W-1], c_q} + {iqmax[Q_W-1], iqmax});
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					// Clamp the integral to the dynamic limit (limit is never negative)
					if (integ_q > lim_q) begin
						integ_q <= lim_q;
					end else if (integ_q < neg_lim) begin
						integ_q <= neg_lim;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (oq_push) begin
						if (job_q.startup) begin
							integ_q <= '0;
						end
						state_q <= job_valid ? ST_WREF : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (job_take) begin
				job_q <= job;
			end
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= y;
		end
	end

	assign empty         = oq_cnt_q == '0;
	assign oq_pop        = pop && !empty;
	assign q_current_ref = oq_mem_q[oq_rd_q];

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + (OQ_PTR_W+1)'(1);
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - (OQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: hdl/decimated_pi_speed_loop.sv
// Decimated PI speed controller with dynamic anti-windup: one sample tick in,
// one q-axis current reference out every period_ticks ticks. A tick that does
// not close a control period is only counted, so such ticks can arrive back
// to back while the job queue is not full. A tick that closes a period queues
// an update (two-deep job queue); the back end works one update at a time in
// steps set by the nine Q16.16 products that share its single 32x32 multiplier,
// and starts the next queued update in the cycle its result enters the
// two-deep result queue. full rises when the job queue is full. No clearing
// pass is needed after reset. Depends on dpsl_pkg and all dpsl_* modules.
module decimated_pi_speed_loop import dpsl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [Q_W-1:0] speed_command,
	input  logic signed [Q_W-1:0] measured_speed,
	input  logic                  startup,
	output logic                  empty,
	input  logic                  pop,
	output logic signed [Q_W-1:0] q_current_ref,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;
	job_t front_job;
	job_t queued_job;
	logic job_push;
	logic jq_full;
	logic jq_valid;
	logic job_take;

	dpsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dpsl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.speed_command  (speed_command),
		.measured_speed (measured_speed),
		.startup        (startup),
		.period_ticks   (cfg.period_ticks),
		.tick_time      (cfg.tick_time),
		.jq_full        (jq_full),
		.job_push       (job_push),
		.job            (front_job)
	);

	dpsl_job_queue u_jq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (front_job),
		.full   (jq_full),
		.valid  (jq_valid),
		.rd_en  (job_take),
		.rd_job (queued_job)
	);

	dpsl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.job_valid     (jq_valid),
		.job           (queued_job),
		.job_take      (job_take),
		.empty         (empty),
		.pop           (pop),
		.q_current_ref (q_current_ref)
	);

endmodule

FILE: hdl/dpsl_checker.sv
// Port-level checker for the speed loop, bound to the top level.
// Depends on dpsl_pkg; mirrors the tick period to track owed results.
module dpsl_checker import dpsl_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input logic signed [Q_W-1:0] q_current_ref,
	input logic                  cfg_wr_en,
	input logic [CFG_ADDR_W-1:0] cfg_addr,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [3:0] MAX_OWED = 4'(JQ_DEPTH + OQ_DEPTH + 1);

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] tick_q;
	logic [PERIOD_W-1:0] tick_nxt;
	logic [3:0]          owed_q;
	logic                in_acc;
	logic                out_acc;
	logic                upd;

	assign in_acc   = push && !full;
	assign out_acc  = pop && !empty;
	assign tick_nxt = tick_q + PERIOD_W'(1);
	assign upd      = in_acc && (tick_nxt >= period_q);

	// Track the period, the tick count and the results still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RST_PERIOD;
			tick_q   <= '0;
			owed_q   <= '0;
		end else begin
			if (cfg_wr_en && (cfg_reg_t'(cfg_addr) == REG_PERIOD_TICKS)) begin
				period_q <= cfg_wdata[PERIOD_W-1:0];
			end
			if (in_acc) begin
				tick_q <= upd ? '0 : tick_nxt;
			end
			owed_q <= owed_q + {3'b0, upd} - {3'b0, out_acc};
		end
	end

	// No result shows without a completed control period behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> owed_q != '0)
		else $error("result shown with no owed update");

	// Back pressure keeps owed results within the block's storage
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= MAX_OWED)
		else $error("more updates accepted than the block can hold");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(q_current_ref))
		else $error("waiting result changed");

endmodule

bind decimated_pi_speed_loop dpsl_checker u_dpsl_checker (.*);
